FILE: rtl/core/bpc_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the barometric compensation core
// no dependencies; imported by every module of the block

package bpc_pkg;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_C1   = 3'd0,
		REG_C2   = 3'd1,
		REG_C3   = 3'd2,
		REG_C4   = 3'd3,
		REG_C5   = 3'd4,
		REG_C6   = 3'd5,
		REG_VSHF = 3'd6
	} bpc_reg_t;

	localparam int RAW_W    = 24;
	localparam int CAL_W    = 16;
	localparam int DT_W     = 26;
	localparam int TEMP_W   = 19;
	localparam int PRES_W   = 32;
	localparam int CFG_IX_W = 3;

	// temperature offset in hundredths of a degree
	localparam logic signed [19:0] TEMP_BASE = 20'sd2000;

	// calibration set seen by the datapath
	typedef struct packed {
		logic [CAL_W-1:0] c1;
		logic [CAL_W-1:0] c2;
		logic [CAL_W-1:0] c3;
		logic [CAL_W-1:0] c4;
		logic [CAL_W-1:0] c5;
		logic [CAL_W-1:0] c6;
		logic             vshift;
	} bpc_cal_t;

	// one queued item: raw pressure and temperature difference
	typedef struct packed {
		logic [RAW_W-1:0]       d1;
		logic signed [DT_W-1:0] dt;
	} bpc_item_t;

endpackage

FILE: rtl/core/bpc_front.sv
`timescale 1ns / 1ps
// front end: takes the raw sample pair and forms the temperature difference
// depends on bpc_pkg

module bpc_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [bpc_pkg::RAW_W-1:0]           raw_pressure,
	input  logic [bpc_pkg::RAW_W-1:0]           raw_temperature,
	input  logic [bpc_pkg::CAL_W-1:0]           ref_temp,
	output logic                                push,
	output bpc_pkg::bpc_item_t                  push_item,
	input  logic                                queue_full
);
	import bpc_pkg::*;

	logic      valid_s1;
	bpc_item_t item_s1;
	logic      take;
	logic signed [DT_W-1:0] dt;

	// difference to the reference temperature, c5 scaled by 256
	assign dt = $signed({2'b00, raw_temperature}) - $signed({2'b00, ref_temp, 8'h00});

	assign push     = valid_s1 && !queue_full;
	assign in_stall = valid_s1 && queue_full;
	assign take     = in_valid && !in_stall;
	assign push_item = item_s1;

	// holding register, refilled in the cycle it drains
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.d1 <= raw_pressure;
			item_s1.dt <= dt;
		end
	end

endmodule

FILE: rtl/core/bpc_fifo.sv
`timescale 1ns / 1ps
// short queue between front end and arithmetic back end
// depends on bpc_pkg

module bpc_fifo #(
	parameter int DEPTH = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  bpc_pkg::bpc_item_t push_item,
	output logic               full,
	input  logic               pop,
	output logic               not_empty,
	output bpc_pkg::bpc_item_t pop_item
);
	import bpc_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	bpc_item_t        mem [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == FULL_CNT);
	assign not_empty = (count_q != '0);
	assign pop_item  = mem[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_item;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/core/bpc_back.sv
`timescale 1ns / 1ps
// back end: five stage compensation pipeline whose last stage is the output register
// depends on bpc_pkg

module bpc_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  bpc_pkg::bpc_cal_t                   cal,
	input  logic                                q_not_empty,
	input  bpc_pkg::bpc_item_t                  q_item,
	output logic                                q_pop,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [bpc_pkg::TEMP_W-1:0]   temp_centideg,
	output logic signed [bpc_pkg::PRES_W-1:0]   pressure_pa
);
	import bpc_pkg::*;

	// stage valids and advance enables
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic adv1, adv2, adv3, adv4, adv5;

	assign adv5 = !v_s5 || !out_stall;
	assign adv4 = !v_s4 || adv5;
	assign adv3 = !v_s3 || adv4;
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;
	assign q_pop = q_not_empty && adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= q_not_empty;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
			if (adv4) v_s4 <= v_s3;
			if (adv5) v_s5 <= v_s4;
		end
	end

	// stage 1: three temperature products
	logic signed [42:0] pt_s1, po_s1, ps_s1;
	logic [RAW_W-1:0]   d1_s1;

	always_ff @(posedge clk) begin
		if (adv1) begin
			pt_s1 <= q_item.dt * $signed({1'b0, cal.c6});
			po_s1 <= q_item.dt * $signed({1'b0, cal.c4});
			ps_s1 <= q_item.dt * $signed({1'b0, cal.c3});
			d1_s1 <= q_item.d1;
		end
	end

	// stage 2: temperature, offset and sensitivity
	logic signed [19:0]     temp_sum;
	logic signed [42:0]     po_sh, ps_sh;
	logic [35:0]            c2_sh, c1_sh;
	logic signed [35:0]     off_c, sens_c;
	logic signed [TEMP_W-1:0] temp_s2, temp_s3, temp_s4;
	logic signed [35:0]     off_s2, off_s3, off_s4;
	logic signed [35:0]     sens_s2;
	logic [RAW_W-1:0]       d1_s2;

	always_comb begin
		temp_sum = $signed(pt_s1[42:23]) + TEMP_BASE;
		po_sh    = cal.vshift ? (po_s1 >>> 7) : (po_s1 >>> 6);
		ps_sh    = cal.vshift ? (ps_s1 >>> 8) : (ps_s1 >>> 7);
		c2_sh    = cal.vshift ? {4'b0, cal.c2, 16'b0} : {3'b0, cal.c2, 17'b0};
		c1_sh    = cal.vshift ? {5'b0, cal.c1, 15'b0} : {4'b0, cal.c1, 16'b0};
		off_c    = $signed(c2_sh) + $signed(po_sh[35:0]);
		sens_c   = $signed(c1_sh) + $signed(ps_sh[35:0]);
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			temp_s2 <= temp_sum[TEMP_W-1:0];
			off_s2  <= off_c;
			sens_s2 <= sens_c;
			d1_s2   <= d1_s1;
		end
	end

	// stage 3: pressure product split in two partial products
	logic [41:0]        pp_lo_s3;
	logic signed [42:0] pp_hi_s3;

	always_ff @(posedge clk) begin
		if (adv3) begin
			pp_lo_s3 <= {18'b0, d1_s2} * {24'b0, sens_s2[17:0]};
			pp_hi_s3 <= $signed({1'b0, d1_s2}) * $signed(sens_s2[35:18]);
			temp_s3  <= temp_s2;
			off_s3   <= off_s2;
		end
	end

	// stage 4: combine partial products
	logic signed [60:0] prod_s4;

	always_ff @(posedge clk) begin
		if (adv4) begin
			prod_s4 <= $signed({pp_hi_s3, 18'b0}) + $signed({19'b0, pp_lo_s3});
			temp_s4 <= temp_s3;
			off_s4  <= off_s3;
		end
	end

	// stage 5: remove offset and scale; the result always fits 32 bits
	logic signed [40:0] p_diff;

	assign p_diff = 41'($signed(prod_s4[60:21])) - 41'(off_s4);

	always_ff @(posedge clk) begin
		if (adv5) begin
			temp_centideg <= temp_s4;
			pressure_pa   <= PRES_W'($signed(p_diff[40:15]));
		end
	end

	assign out_valid = v_s5;

endmodule

FILE: rtl/core/baro_pressure_temp_compensation_core.sv
`timescale 1ns / 1ps
// First-order barometric compensation core.
// Input channel: in_valid / in_stall with raw_pressure (D1) and
// raw_temperature (D2); one transfer per cycle is sustained while in_stall is low.
// Output channel: out_valid / out_stall with temp_centideg (hundredths of a
// degree) and pressure_pa (pascals), one result per input pair, in order.
// Configuration: cfg_we writes cfg_data into register cfg_index
// (0..5 calibration words C1..C6, 6 variant shift); other indexes are ignored.
// Write only while no sample is in flight.
// Path from input transfer to out_valid with an empty queue: the front
// register loads at the transfer, then the queue slot, then the five
// arithmetic stages.
// Throughput: one pair per cycle while out_stall is low, set by the pipelined multiplier stages.
// When out_stall is held the arithmetic stages fill, then the queue, then
// the front register, and only then is in_stall raised.
// Reset clears all calibration registers to zero and empties the pipeline.
// depends on bpc_pkg, bpc_front, bpc_fifo, bpc_back

module baro_pressure_temp_compensation_core #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [bpc_pkg::RAW_W-1:0]           raw_pressure,
	input  logic [bpc_pkg::RAW_W-1:0]           raw_temperature,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [bpc_pkg::TEMP_W-1:0]   temp_centideg,
	output logic signed [bpc_pkg::PRES_W-1:0]   pressure_pa,
	input  logic                                cfg_we,
	input  logic [bpc_pkg::CFG_IX_W-1:0]        cfg_index,
	input  logic [bpc_pkg::CAL_W-1:0]           cfg_data
);
	import bpc_pkg::*;

	bpc_cal_t  cal_q;
	bpc_item_t push_item, pop_item;
	logic      push, pop, queue_full, queue_not_empty;

	// calibration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_C1:   cal_q.c1     <= cfg_data;
				REG_C2:   cal_q.c2     <= cfg_data;
				REG_C3:   cal_q.c3     <= cfg_data;
				REG_C4:   cal_q.c4     <= cfg_data;
				REG_C5:   cal_q.c5     <= cfg_data;
				REG_C6:   cal_q.c6     <= cfg_data;
				REG_VSHF: cal_q.vshift <= cfg_data[0];
				default:  ;
			endcase
		end
	end

	// front end
	bpc_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.raw_pressure    (raw_pressure),
		.raw_temperature (raw_temperature),
		.ref_temp        (cal_q.c5),
		.push            (push),
		.push_item       (push_item),
		.queue_full      (queue_full)
	);

	// decoupling queue
	bpc_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (queue_full),
		.pop       (pop),
		.not_empty (queue_not_empty),
		.pop_item  (pop_item)
	);

	// arithmetic back end
	bpc_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cal           (cal_q),
		.q_not_empty   (queue_not_empty),
		.q_item        (pop_item),
		.q_pop         (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.temp_centideg (temp_centideg),
		.pressure_pa   (pressure_pa)
	);

endmodule

FILE: test/baro_pressure_temp_compensation_checker.sv
`timescale 1ns / 1ps
// compensation checker: watches the sample and result channels of the core
// depends on bpc_pkg; keeps its own copy of the calibration set

module baro_pressure_temp_compensation_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic                              in_stall,
	input  logic [bpc_pkg::RAW_W-1:0]         raw_pressure,
	input  logic [bpc_pkg::RAW_W-1:0]         raw_temperature,
	input  logic                              out_valid,
	input  logic                              out_stall,
	input  logic signed [bpc_pkg::TEMP_W-1:0] temp_centideg,
	input  logic signed [bpc_pkg::PRES_W-1:0] pressure_pa,
	input  logic                              cfg_we,
	input  logic [bpc_pkg::CFG_IX_W-1:0]      cfg_index,
	input  logic [bpc_pkg::CAL_W-1:0]         cfg_data,
	output int                                mismatch_count,
	output int                                readings_in_flight
);

	import bpc_pkg::*;

	localparam longint PRES_MAX = 64'sd2147483647;
	localparam longint PRES_MIN = -64'sd2147483648;

	// one compensated reading
	typedef struct packed {
		logic signed [TEMP_W-1:0] temp;
		logic signed [PRES_W-1:0] pres;
	} reading_t;

	bpc_cal_t cal_copy = '0;
	reading_t readings_q[$];
	reading_t oldest;

	initial mismatch_count = 0;
	initial readings_in_flight = 0;

	// first-order compensation, floor shifts on signed 64-bit values
	function automatic reading_t compensate_pair(input logic [RAW_W-1:0] d1,
			input logic [RAW_W-1:0] d2, input bpc_cal_t k);
		longint dt, temp, off, sens, pres;
		int unsigned v;
		reading_t r;
		v = k.vshift;
		dt = longint'(d2) - longint'(k.c5) * 256;
		temp = 2000 + ((dt * longint'(k.c6)) >>> 23);
		off = (longint'(k.c2) << (17 - v)) + ((longint'(k.c4) * dt) >>> (6 + v));
		sens = (longint'(k.c1) << (16 - v)) + ((longint'(k.c3) * dt) >>> (7 + v));
		pres = (((longint'(d1) * sens) >>> 21) - off) >>> 15;
		if (pres > PRES_MAX)
			pres = PRES_MAX;
		if (pres < PRES_MIN)
			pres = PRES_MIN;
		r.temp = temp[TEMP_W-1:0];
		r.pres = pres[PRES_W-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			readings_q.delete();
			cal_copy = '0;
			readings_in_flight = 0;
		end else begin
			// result transfer against the oldest predicted reading
			if (out_valid && !out_stall) begin
				if (readings_q.size() == 0) begin
					$display("%0t: result with none pending: temp %0d pressure %0d",
						$time, temp_centideg, pressure_pa);
					mismatch_count++;
				end else begin
					oldest = readings_q.pop_front();
					if (temp_centideg !== oldest.temp) begin
						$display("%0t: temp_centideg expected %0d actual %0d",
							$time, oldest.temp, temp_centideg);
						mismatch_count++;
					end
					if (pressure_pa !== oldest.pres) begin
						$display("%0t: pressure_pa expected %0d actual %0d",
							$time, oldest.pres, pressure_pa);
						mismatch_count++;
					end
				end
			end
			// sample transfer: predict with the calibration in force
			if (in_valid && !in_stall)
				readings_q.push_back(compensate_pair(raw_pressure, raw_temperature, cal_copy));
			// register writes, unknown indexes dropped
			if (cfg_we) begin
				case (cfg_index)
					REG_C1: cal_copy.c1 = cfg_data;
					REG_C2: cal_copy.c2 = cfg_data;
					REG_C3: cal_copy.c3 = cfg_data;
					REG_C4: cal_copy.c4 = cfg_data;
					REG_C5: cal_copy.c5 = cfg_data;
					REG_C6: cal_copy.c6 = cfg_data;
					REG_VSHF: cal_copy.vshift = cfg_data[0];
					default: ;
				endcase
			end
			readings_in_flight = readings_q.size();
		end
	end

endmodule

FILE: test/baro_pressure_temp_compensation_core_tb.sv
`timescale 1ns / 1ps
// stimulus and verdict for the barometric compensation core
// depends on bpc_pkg, the core and baro_pressure_temp_compensation_checker

module baro_pressure_temp_compensation_core_tb;

	import bpc_pkg::*;

	localparam logic [CFG_IX_W-1:0] CFG_IX_UNUSED = 3'd7;
	localparam logic [RAW_W-1:0]    RAW_MAX = 24'hFFFFFF;
	localparam int ITEMS_PER_PHASE = 240;
	localparam int RANDOM_PHASES = 8;
	localparam int LONG_HOLD = 300;
	localparam int SETTLE_CYCLES = 20;
	localparam int CYCLE_LIMIT = 400000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [RAW_W-1:0] raw_pressure;
	logic [RAW_W-1:0] raw_temperature;
	logic out_valid;
	logic out_stall;
	logic signed [TEMP_W-1:0] temp_centideg;
	logic signed [PRES_W-1:0] pressure_pa;
	logic cfg_we;
	logic [CFG_IX_W-1:0] cfg_index;
	logic [CAL_W-1:0] cfg_data;

	int mismatch_count;
	int readings_in_flight;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int rx_hold_len = 0;
	int cycle_count = 0;

	bpc_cal_t cal_set;
	logic [CAL_W-1:0] vshift_word;

	baro_pressure_temp_compensation_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.raw_pressure(raw_pressure),
		.raw_temperature(raw_temperature),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.temp_centideg(temp_centideg),
		.pressure_pa(pressure_pa),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	baro_pressure_temp_compensation_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.raw_pressure(raw_pressure),
		.raw_temperature(raw_temperature),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.temp_centideg(temp_centideg),
		.pressure_pa(pressure_pa),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.mismatch_count(mismatch_count),
		.readings_in_flight(readings_in_flight)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// result side: random stall, or a long hold counted here
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_len > 0) begin
				out_stall <= 1'b1;
				rx_hold_len = rx_hold_len - 1;
			end else begin
				out_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	// one sample transfer, with random idle cycles ahead of it
	task automatic send_pair(input logic [RAW_W-1:0] d1, input logic [RAW_W-1:0] d2);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		raw_pressure <= d1;
		raw_temperature <= d2;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	// stop offering and wait for every pending reading
	task automatic drain_readings();
		in_valid <= 1'b0;
		while (readings_in_flight != 0)
			@(negedge clk);
	endtask

	// write the whole calibration set, then a write to an unused index
	task automatic write_calibration();
		cfg_we <= 1'b1;
		cfg_index <= REG_C1;
		cfg_data <= cal_set.c1;
		@(negedge clk);
		cfg_index <= REG_C2;
		cfg_data <= cal_set.c2;
		@(negedge clk);
		cfg_index <= REG_C3;
		cfg_data <= cal_set.c3;
		@(negedge clk);
		cfg_index <= REG_C4;
		cfg_data <= cal_set.c4;
		@(negedge clk);
		cfg_index <= REG_C5;
		cfg_data <= cal_set.c5;
		@(negedge clk);
		cfg_index <= REG_C6;
		cfg_data <= cal_set.c6;
		@(negedge clk);
		cfg_index <= REG_VSHF;
		cfg_data <= vshift_word;
		@(negedge clk);
		cfg_index <= CFG_IX_UNUSED;
		cfg_data <= CAL_W'($urandom);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [CAL_W-1:0] pick_cal_word();
		case ($urandom_range(5))
			0: return '0;
			1: return '1;
			default: return CAL_W'($urandom);
		endcase
	endfunction

	function automatic logic [RAW_W-1:0] pick_raw();
		case ($urandom_range(7))
			0: return '0;
			1: return RAW_MAX;
			default: return RAW_W'($urandom);
		endcase
	endfunction

	// temperature word close to the reference point, around dt of zero
	function automatic logic [RAW_W-1:0] near_reference();
		int t;
		t = int'(cal_set.c5) * 256 + int'($urandom_range(64)) - 32;
		if (t < 0)
			t = 0;
		if (t > int'(RAW_MAX))
			t = int'(RAW_MAX);
		return t[RAW_W-1:0];
	endfunction

	function automatic void typical_cal();
		cal_set.c1 = 16'd40127;
		cal_set.c2 = 16'd36924;
		cal_set.c3 = 16'd23317;
		cal_set.c4 = 16'd23282;
		cal_set.c5 = 16'd33464;
		cal_set.c6 = 16'd28312;
	endfunction

	function automatic void random_cal();
		cal_set.c1 = pick_cal_word();
		cal_set.c2 = pick_cal_word();
		cal_set.c3 = pick_cal_word();
		cal_set.c4 = pick_cal_word();
		cal_set.c5 = pick_cal_word();
		cal_set.c6 = pick_cal_word();
	endfunction

	// stimulus and verdict
	initial begin
		logic [RAW_W-1:0] d1;
		logic [RAW_W-1:0] d2;
		arst_n = 1'b0;
		in_valid = 1'b0;
		raw_pressure = '0;
		raw_temperature = '0;
		cfg_we = 1'b0;
		cfg_index = REG_C1;
		cfg_data = '0;
		cal_set = '0;
		vshift_word = '0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// calibration still at its reset value
		send_pair(RAW_MAX, RAW_MAX);
		send_pair('0, '0);
		drain_readings();

		// typical calibration: field extremes and the reference point
		typical_cal();
		vshift_word = '0;
		write_calibration();
		send_pair('0, '0);
		send_pair(RAW_MAX, RAW_MAX);
		send_pair('0, RAW_MAX);
		send_pair(RAW_MAX, '0);
		send_pair(24'h800000, {cal_set.c5, 8'h00});
		send_pair(24'h800000, {cal_set.c5, 8'h00} - 24'd1);
		send_pair(24'h7FFFFF, {cal_set.c5, 8'h00} + 24'd1);
		drain_readings();

		// every word at its maximum, both variants: temperature extremes
		cal_set = '1;
		vshift_word = 16'hFFFF;
		write_calibration();
		send_pair(RAW_MAX, RAW_MAX);
		send_pair(RAW_MAX, '0);
		send_pair('0, '0);
		send_pair(24'h800000, 24'h800000);
		drain_readings();
		vshift_word = 16'hFFFE;
		write_calibration();
		send_pair(RAW_MAX, '0);
		send_pair(RAW_MAX, RAW_MAX);
		send_pair('0, RAW_MAX);

		// random phases over calibration sets and idle patterns
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			drain_readings();
			case (ph)
				0, 1: typical_cal();
				2: cal_set = '1;
				3: cal_set = '0;
				5: begin
					cal_set = '1;
					cal_set.c5 = '0;
				end
				6: cal_set = '1;
				default: random_cal();
			endcase
			case (ph)
				1, 2: vshift_word = CAL_W'($urandom) | 16'h0001;
				3, 5: vshift_word = '0;
				default: vshift_word = CAL_W'($urandom);
			endcase
			write_calibration();
			case (ph % 4)
				0: begin
					send_idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					send_idle_pct = 78;
					stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct = 78;
				end
				default: begin
					send_idle_pct = 12;
					stall_pct = 12;
				end
			endcase
			// back-pressure long enough to fill the core
			if (ph % 4 == 0)
				rx_hold_len = LONG_HOLD;
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				d1 = pick_raw();
				d2 = ($urandom_range(7) == 0) ? near_reference() : pick_raw();
				send_pair(d1, d2);
			end
		end

		drain_readings();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
